// ===== design/flight_phase_sequencer_defines.svh =====
// ----------------------------------------------------------------------------
// Flight phase sequencer assertion macros
// Shared concurrent assertion forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef FLIGHT_PHASE_SEQUENCER_DEFINES_SVH
`define FLIGHT_PHASE_SEQUENCER_DEFINES_SVH

// Assertion that is checked only outside reset.
`define FPS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion that is also checked while reset is applied.
`define FPS_ASSERT_ANY(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/fps_pkg.sv =====
// ----------------------------------------------------------------------------
// Flight phase sequencer package
// Phase codes, register indexes, timing constants and shared types.
// ----------------------------------------------------------------------------
package fps_pkg;

  localparam int unsigned PHASE_W = 4;
  localparam int unsigned ACC_W   = 16;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned MS_W    = 20;
  localparam int unsigned ADDR_W  = 3;
  localparam int unsigned DATA_W  = 20;

  localparam logic [PHASE_W-1:0] PH_ABORT        = 4'd0;
  localparam logic [PHASE_W-1:0] PH_INIT         = 4'd1;
  localparam logic [PHASE_W-1:0] PH_IDLE         = 4'd2;
  localparam logic [PHASE_W-1:0] PH_LAUNCH_DET   = 4'd3;
  localparam logic [PHASE_W-1:0] PH_BOOST        = 4'd4;
  localparam logic [PHASE_W-1:0] PH_BURNOUT_DET  = 4'd5;
  localparam logic [PHASE_W-1:0] PH_COAST_PRE    = 4'd6;
  localparam logic [PHASE_W-1:0] PH_COAST_GUIDED = 4'd7;
  localparam logic [PHASE_W-1:0] PH_APOGEE_DET   = 4'd8;
  localparam logic [PHASE_W-1:0] PH_APOGEE       = 4'd9;
  localparam logic [PHASE_W-1:0] PH_DROGUE_DET   = 4'd10;
  localparam logic [PHASE_W-1:0] PH_DROGUE       = 4'd11;
  localparam logic [PHASE_W-1:0] PH_MAIN_DET     = 4'd12;
  localparam logic [PHASE_W-1:0] PH_MAIN         = 4'd13;
  localparam logic [PHASE_W-1:0] PH_LANDED_DET   = 4'd14;
  localparam logic [PHASE_W-1:0] PH_LANDED       = 4'd15;

  localparam logic [ADDR_W-1:0] REG_LAUNCH_LEVEL = 3'd0;
  localparam logic [ADDR_W-1:0] REG_COAST_LEVEL  = 3'd1;
  localparam logic [ADDR_W-1:0] REG_LAUNCH_HOLD  = 3'd2;
  localparam logic [ADDR_W-1:0] REG_BURN_LIMIT   = 3'd3;
  localparam logic [ADDR_W-1:0] REG_BURNOUT_HOLD = 3'd4;
  localparam logic [ADDR_W-1:0] REG_GUIDANCE_DLY = 3'd5;
  localparam logic [ADDR_W-1:0] REG_COAST_APOGEE = 3'd6;
  localparam logic [ADDR_W-1:0] REG_APOGEE_WAIT  = 3'd7;

  localparam logic [MS_W-1:0] DROGUE_WAIT_MS = 20'd1000;
  localparam logic [MS_W-1:0] MAIN_WAIT_MS   = 20'd1000;

  typedef struct packed {
    logic signed [ACC_W-1:0] launch_accel_level;
    logic signed [ACC_W-1:0] coast_accel_level;
    logic [MS_W-1:0]         launch_hold_ms;
    logic [MS_W-1:0]         burn_limit_ms;
    logic [MS_W-1:0]         burnout_hold_ms;
    logic [MS_W-1:0]         guidance_delay_ms;
    logic [MS_W-1:0]         coast_to_apogee_ms;
    logic [MS_W-1:0]         apogee_wait_ms;
  } cfg_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [TIME_W-1:0]  launch_stamp;
    logic [TIME_W-1:0]  burnout_stamp;
    logic [TIME_W-1:0]  apogee_stamp;
    logic [TIME_W-1:0]  drogue_stamp;
    logic [TIME_W-1:0]  main_stamp;
  } seq_state_t;

endpackage

// ===== design/flight_phase_sequencer.sv =====
// ----------------------------------------------------------------------------
// Flight phase sequencer
// Advances the flight phase once per input sample and returns the new phase.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake             Payload
// in_       input      in_valid / in_ready   accel_z, now_ms, abort_request
// out_      output     out_valid / out_ready flight_state
// cfg_      input      cfg_we                cfg_addr, cfg_wdata
//
// One transaction per cycle unless stalled; input and output are each registered.
// The rate is set by the phase register, updated in one pass from the input register.
// Synchronous reset returns the phase to init and clears the timestamps and limits.
// A stalled output holds its result while one more sample waits in the input register.
// ----------------------------------------------------------------------------
module flight_phase_sequencer (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [fps_pkg::ACC_W-1:0]  in_accel_z,
  input  logic [fps_pkg::TIME_W-1:0]        in_now_ms,
  input  logic                              in_abort_request,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [fps_pkg::PHASE_W-1:0]       out_flight_state,
  input  logic                              cfg_we,
  input  logic [fps_pkg::ADDR_W-1:0]        cfg_addr,
  input  logic [fps_pkg::DATA_W-1:0]        cfg_wdata
);
  import fps_pkg::*;

  cfg_t                    cfg;
  seq_state_t              st_r;
  seq_state_t              st_nxt;
  logic                    s1_vld_r;
  logic signed [ACC_W-1:0] s1_accel_r;
  logic [TIME_W-1:0]       s1_now_r;
  logic                    s1_abort_r;
  logic                    out_vld_r;
  logic [PHASE_W-1:0]      out_state_r;
  logic                    advance;

  fps_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  fps_step u_step (
    .cfg           (cfg),
    .cur           (st_r),
    .accel_z       (s1_accel_r),
    .now_ms        (s1_now_r),
    .abort_request (s1_abort_r),
    .nxt           (st_nxt)
  );

  assign advance  = s1_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !s1_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r        <= 1'b0;
      out_vld_r       <= 1'b0;
      st_r            <= '{PH_INIT, '0, '0, '0, '0, '0};
    end else begin
      if (in_ready) begin
        s1_vld_r <= in_valid;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
        st_r      <= st_nxt;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_accel_r <= in_accel_z;
      s1_now_r   <= in_now_ms;
      s1_abort_r <= in_abort_request;
    end
    if (advance) begin
      out_state_r <= st_nxt.phase;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_flight_state = out_state_r;

endmodule

// ===== design/fps_cfg.sv =====
// ----------------------------------------------------------------------------
// Flight phase sequencer configuration registers
// Holds the acceleration levels and timing limits written over the port.
// ----------------------------------------------------------------------------
module fps_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [fps_pkg::ADDR_W-1:0]  cfg_addr,
  input  logic [fps_pkg::DATA_W-1:0]  cfg_wdata,
  output fps_pkg::cfg_t               cfg
);
  import fps_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        REG_LAUNCH_LEVEL: cfg_nxt.launch_accel_level = $signed(cfg_wdata[ACC_W-1:0]);
        REG_COAST_LEVEL:  cfg_nxt.coast_accel_level  = $signed(cfg_wdata[ACC_W-1:0]);
        REG_LAUNCH_HOLD:  cfg_nxt.launch_hold_ms     = cfg_wdata[MS_W-1:0];
        REG_BURN_LIMIT:   cfg_nxt.burn_limit_ms      = cfg_wdata[MS_W-1:0];
        REG_BURNOUT_HOLD: cfg_nxt.burnout_hold_ms    = cfg_wdata[MS_W-1:0];
        REG_GUIDANCE_DLY: cfg_nxt.guidance_delay_ms  = cfg_wdata[MS_W-1:0];
        REG_COAST_APOGEE: cfg_nxt.coast_to_apogee_ms = cfg_wdata[MS_W-1:0];
        REG_APOGEE_WAIT:  cfg_nxt.apogee_wait_ms     = cfg_wdata[MS_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== design/fps_step.sv =====
// ----------------------------------------------------------------------------
// Flight phase sequencer transition logic
// Computes the next phase and timestamps from one registered sample.
// ----------------------------------------------------------------------------
module fps_step (
  input  fps_pkg::cfg_t                     cfg,
  input  fps_pkg::seq_state_t               cur,
  input  logic signed [fps_pkg::ACC_W-1:0]  accel_z,
  input  logic [fps_pkg::TIME_W-1:0]        now_ms,
  input  logic                              abort_request,
  output fps_pkg::seq_state_t               nxt
);
  import fps_pkg::*;

  logic [PHASE_W-1:0] ph;
  logic [TIME_W-1:0]  stamp_sel;
  logic [MS_W-1:0]    limit_sel;
  logic [TIME_W-1:0]  elapsed;
  logic               over_limit;
  logic               at_limit;

  assign ph = abort_request ? PH_ABORT : cur.phase;

  // One elapsed-time subtractor serves every timed phase.
  always_comb begin
    stamp_sel = cur.launch_stamp;
    limit_sel = cfg.launch_hold_ms;
    unique case (ph)
      PH_BOOST: begin
        limit_sel = cfg.burn_limit_ms;
      end
      PH_BURNOUT_DET: begin
        stamp_sel = cur.burnout_stamp;
        limit_sel = cfg.burnout_hold_ms;
      end
      PH_COAST_PRE: begin
        stamp_sel = cur.burnout_stamp;
        limit_sel = cfg.guidance_delay_ms;
      end
      PH_COAST_GUIDED: begin
        stamp_sel = cur.burnout_stamp;
        limit_sel = cfg.coast_to_apogee_ms;
      end
      PH_APOGEE: begin
        stamp_sel = cur.apogee_stamp;
        limit_sel = cfg.apogee_wait_ms;
      end
      PH_DROGUE: begin
        stamp_sel = cur.drogue_stamp;
        limit_sel = DROGUE_WAIT_MS;
      end
      PH_MAIN: begin
        stamp_sel = cur.main_stamp;
        limit_sel = MAIN_WAIT_MS;
      end
      default: begin
      end
    endcase
  end

  assign elapsed    = now_ms - stamp_sel;
  assign over_limit = elapsed >  {{(TIME_W-MS_W){1'b0}}, limit_sel};
  assign at_limit   = elapsed >= {{(TIME_W-MS_W){1'b0}}, limit_sel};

  always_comb begin
    nxt       = cur;
    nxt.phase = ph;
    unique case (ph)
      PH_ABORT: begin
      end
      PH_INIT: begin
        nxt.phase = PH_IDLE;
      end
      PH_IDLE: begin
        if (accel_z > cfg.launch_accel_level) begin
          nxt.launch_stamp = now_ms;
          nxt.phase        = PH_LAUNCH_DET;
        end
      end
      PH_LAUNCH_DET: begin
        if (accel_z < cfg.launch_accel_level) begin
          nxt.phase = PH_IDLE;
        end else if (over_limit) begin
          nxt.phase = PH_BOOST;
        end
      end
      PH_BOOST: begin
        if (accel_z < cfg.coast_accel_level) begin
          nxt.burnout_stamp = now_ms;
          nxt.phase         = PH_BURNOUT_DET;
        end else if (at_limit) begin
          nxt.burnout_stamp = now_ms;
          nxt.phase         = PH_COAST_PRE;
        end
      end
      PH_BURNOUT_DET: begin
        if (accel_z > cfg.coast_accel_level) begin
          nxt.phase = PH_BOOST;
        end else if (over_limit) begin
          nxt.phase = PH_COAST_PRE;
        end
      end
      PH_COAST_PRE: begin
        if (over_limit) begin
          nxt.phase = PH_COAST_GUIDED;
        end
      end
      PH_COAST_GUIDED: begin
        if (over_limit) begin
          nxt.apogee_stamp = now_ms;
          nxt.phase        = PH_APOGEE_DET;
        end
      end
      PH_APOGEE_DET: begin
        nxt.phase = PH_APOGEE;
      end
      PH_APOGEE: begin
        if (over_limit) begin
          nxt.drogue_stamp = now_ms;
          nxt.phase        = PH_DROGUE_DET;
        end
      end
      PH_DROGUE_DET: begin
        nxt.phase = PH_DROGUE;
      end
      PH_DROGUE: begin
        if (over_limit) begin
          nxt.main_stamp = now_ms;
          nxt.phase      = PH_MAIN_DET;
        end
      end
      PH_MAIN_DET: begin
        nxt.phase = PH_MAIN;
      end
      PH_MAIN: begin
        if (over_limit) begin
          nxt.phase = PH_LANDED_DET;
        end
      end
      PH_LANDED_DET: begin
        nxt.phase = PH_LANDED;
      end
      PH_LANDED: begin
      end
    endcase
  end

endmodule

// ===== design/fps_checker.sv =====
// ----------------------------------------------------------------------------
// Flight phase sequencer port checker
// Watches the top-level ports for reset, output hold and sticky phase behavior.
// ----------------------------------------------------------------------------
`include "flight_phase_sequencer_defines.svh"

module fps_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [fps_pkg::PHASE_W-1:0] out_flight_state
);
  import fps_pkg::*;

  logic               last_vld_r;
  logic [PHASE_W-1:0] last_state_r;
  logic               out_xfer;

  assign out_xfer = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_vld_r   <= 1'b0;
      last_state_r <= PH_INIT;
    end else if (out_xfer) begin
      last_vld_r   <= 1'b1;
      last_state_r <= out_flight_state;
    end
  end

  `FPS_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_flight_state), "stalled output transaction changed")
  `FPS_ASSERT_ANY(a_reset_empty, clk, !rst_n |=> !out_valid, "output valid right after reset")
  `FPS_ASSERT(a_abort_sticky, clk, rst_n, out_xfer && last_vld_r && last_state_r == PH_ABORT |-> out_flight_state == PH_ABORT, "left the abort phase")
  `FPS_ASSERT(a_landed_sticky, clk, rst_n, out_xfer && last_vld_r && last_state_r == PH_LANDED |-> out_flight_state == PH_LANDED || out_flight_state == PH_ABORT, "left the landed phase")

endmodule

bind flight_phase_sequencer fps_checker u_fps_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_flight_state (out_flight_state)
);
